>>> hw/rtl/bsr_pkg.sv
// shared types, sizes and slot arithmetic for the byte stream reassembler
package bsr_pkg;

  // window store depth and stream index width
  localparam int WIN_DEPTH = 64;
  localparam int IDX_W     = 32;
  localparam int SLOT_W    = (WIN_DEPTH > 1) ? $clog2(WIN_DEPTH) : 1;

  // fixed field widths
  localparam int BYTE_W    = 8;
  localparam int WIN_CFG_W = 7;
  localparam int HELD_W    = 7;
  localparam logic [WIN_CFG_W-1:0] WIN_RESET = WIN_CFG_W'(64);

  // command queue between front and back
  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  // one classified input beat
  typedef struct packed {
    logic              has_data;
    logic              ends;
    logic [IDX_W-1:0]  idx;
    logic [BYTE_W-1:0] data;
    logic [IDX_W-1:0]  end_val;
  } cmd_t;

  // back end sequencer states
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_LOOK,
    BK_EMIT
  } back_state_t;

  // circular slot add, both operands below WIN_DEPTH
  function automatic logic [SLOT_W-1:0] slot_add(input logic [SLOT_W-1:0] a,
                                                 input logic [SLOT_W-1:0] b);
    logic [SLOT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= (SLOT_W+1)'(WIN_DEPTH)) begin
      s = s - (SLOT_W+1)'(WIN_DEPTH);
    end
    return s[SLOT_W-1:0];
  endfunction

endpackage

>>> hw/rtl/bsr_front.sv
// input stage: takes beats, works out the end position and registers a command
module bsr_front (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       has_data,
  input  logic [bsr_pkg::IDX_W-1:0]  byte_index,
  input  logic [bsr_pkg::BYTE_W-1:0] data_byte,
  input  logic                       ends_stream,
  output logic                       cmd_valid,
  input  logic                       cmd_ready,
  output bsr_pkg::cmd_t              cmd
);
  import bsr_pkg::*;

  logic stage_valid;
  cmd_t stage;

  // stage frees when empty or when the queue takes it
  assign in_ready  = !stage_valid || cmd_ready;
  assign cmd_valid = stage_valid;
  assign cmd       = stage;

  // stage valid
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
  end

  // classify: end marker lands after the byte, or at the index when empty
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stage.has_data <= has_data;
      stage.ends     <= ends_stream;
      stage.idx      <= byte_index;
      stage.data     <= data_byte;
      stage.end_val  <= byte_index + {{(IDX_W-1){1'b0}}, has_data};
    end
  end

endmodule

>>> hw/rtl/bsr_fifo.sv
// short command queue between front and back
module bsr_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          push_valid,
  output logic          push_ready,
  input  bsr_pkg::cmd_t push_cmd,
  output logic          pop_valid,
  input  logic          pop_ready,
  output bsr_pkg::cmd_t pop_cmd
);
  import bsr_pkg::*;

  cmd_t              entries [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push;
  logic              do_pop;

  assign push_ready = (count != QCNT_W'(QDEPTH));
  assign pop_valid  = (count != '0);
  assign pop_cmd    = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  // entry write
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

endmodule

>>> hw/rtl/bsr_back.sv
// back end: window store, held marks, in-order drain and result register
module bsr_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [bsr_pkg::WIN_CFG_W-1:0] cfg_data,
  input  logic                          cmd_valid,
  output logic                          cmd_ready,
  input  bsr_pkg::cmd_t                 cmd,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          has_byte,
  output logic [bsr_pkg::BYTE_W-1:0]    out_byte,
  output logic [bsr_pkg::IDX_W-1:0]     out_position,
  output logic                          last,
  output logic [bsr_pkg::HELD_W-1:0]    held_bytes,
  output logic                          nothing_held,
  output logic                          stream_ended
);
  import bsr_pkg::*;

  // window store, read port registered
  logic [BYTE_W-1:0]    byte_store [WIN_DEPTH];
  logic [BYTE_W-1:0]    rd_byte;
  logic [WIN_DEPTH-1:0] held_mask;

  logic [WIN_CFG_W-1:0] window_size;
  logic [IDX_W-1:0]     next_expected;
  logic [IDX_W-1:0]     end_position;
  logic                 end_known;
  logic [HELD_W-1:0]    held_count;
  logic                 ended_flag;
  logic [SLOT_W-1:0]    head_slot;

  back_state_t state;
  back_state_t state_next;

  logic [WIN_CFG_W-1:0] eff_win;
  logic [IDX_W-1:0]     offset;
  logic                 in_win;
  logic [SLOT_W-1:0]    wr_slot;
  logic [SLOT_W-1:0]    head_plus1;
  logic [IDX_W-1:0]     next_plus1;
  logic [HELD_W-1:0]    count_dec;
  logic                 out_free;
  logic                 do_insert;
  logic                 emit_byte;
  logic                 emit_status;
  logic                 byte_last;
  logic                 ended_after;

  // window check against the current head
  assign eff_win    = (window_size > WIN_CFG_W'(WIN_DEPTH)) ? WIN_CFG_W'(WIN_DEPTH)
                                                            : window_size;
  assign offset     = cmd.idx - next_expected;
  assign in_win     = cmd.has_data && (offset < {{(IDX_W-WIN_CFG_W){1'b0}}, eff_win});
  assign wr_slot    = slot_add(head_slot, offset[SLOT_W-1:0]);
  assign head_plus1 = (head_slot == SLOT_W'(WIN_DEPTH - 1)) ? '0 : head_slot + 1'b1;
  assign next_plus1 = next_expected + 1'b1;
  assign count_dec  = (held_count != '0) ? held_count - 1'b1 : held_count;
  assign out_free   = !out_valid || out_ready;
  assign byte_last  = !held_mask[head_plus1];
  assign ended_after = ended_flag || (end_known && (next_plus1 == end_position));

  // sequencer: insert a command, drain one byte per visit or send a status
  always_comb begin
    state_next  = state;
    cmd_ready   = 1'b0;
    do_insert   = 1'b0;
    emit_byte   = 1'b0;
    emit_status = 1'b0;
    unique case (state)
      BK_IDLE: begin
        cmd_ready = 1'b1;
        if (cmd_valid) begin
          do_insert  = 1'b1;
          state_next = BK_LOOK;
        end
      end
      BK_LOOK: begin
        state_next = BK_EMIT;
      end
      BK_EMIT: begin
        if (out_free) begin
          if (held_mask[head_slot]) begin
            emit_byte  = 1'b1;
            state_next = byte_last ? BK_IDLE : BK_LOOK;
          end else begin
            emit_status = 1'b1;
            state_next  = BK_IDLE;
          end
        end
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // store write and head read
  always_ff @(posedge clk) begin
    if (do_insert && in_win) begin
      byte_store[wr_slot] <= cmd.data;
    end
    rd_byte <= byte_store[head_slot];
  end

  // window bookkeeping and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      window_size   <= WIN_RESET;
      held_mask     <= '0;
      next_expected <= '0;
      end_position  <= '0;
      end_known     <= 1'b0;
      held_count    <= '0;
      ended_flag    <= 1'b0;
      head_slot     <= '0;
    end else begin
      if (cfg_write) begin
        window_size <= cfg_data;
      end
      if (do_insert) begin
        if (cmd.ends) begin
          end_position <= cmd.end_val;
          end_known    <= 1'b1;
        end
        if (in_win && !held_mask[wr_slot]) begin
          held_mask[wr_slot] <= 1'b1;
          held_count         <= held_count + 1'b1;
        end
      end
      // end check once the insert has settled
      if (state == BK_LOOK && end_known && (next_expected == end_position)) begin
        ended_flag <= 1'b1;
      end
      if (emit_byte) begin
        held_mask[head_slot] <= 1'b0;
        held_count           <= count_dec;
        next_expected        <= next_plus1;
        head_slot            <= head_plus1;
        ended_flag           <= ended_after;
      end
    end
  end

  // result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_byte || emit_status) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (emit_byte) begin
      has_byte     <= 1'b1;
      out_byte     <= rd_byte;
      out_position <= next_expected;
      last         <= byte_last;
      held_bytes   <= count_dec;
      nothing_held <= (count_dec == '0);
      stream_ended <= ended_after;
    end else if (emit_status) begin
      has_byte     <= 1'b0;
      out_byte     <= '0;
      out_position <= next_expected;
      last         <= 1'b1;
      held_bytes   <= held_count;
      nothing_held <= (held_count == '0);
      stream_ended <= ended_flag;
    end
  end

endmodule

>>> hw/rtl/byte_stream_reassembler.sv
// top level of the byte stream reassembler
//
//  channel   handshake              payload
//  input     in_valid / in_ready    has_data, byte_index, data_byte, ends_stream
//  output    out_valid / out_ready  has_byte, out_byte, out_position, last,
//                                   held_bytes, nothing_held, stream_ended
//  config    cfg_write              cfg_data (window_size)
//
// an item is inserted, then each delivered byte passes through a look and an emit state,
// or the single status result does when nothing is delivered; the back end takes no
// new item until it has finished draining the last one
// a two-entry command queue lets the front keep taking beats while the back drains
// rst is synchronous: window empty, indices zero, window_size back to 64
// a stalled output holds the drain in place; nothing is lost or repeated
module byte_stream_reassembler (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [bsr_pkg::WIN_CFG_W-1:0] cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          has_data,
  input  logic [bsr_pkg::IDX_W-1:0]     byte_index,
  input  logic [bsr_pkg::BYTE_W-1:0]    data_byte,
  input  logic                          ends_stream,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          has_byte,
  output logic [bsr_pkg::BYTE_W-1:0]    out_byte,
  output logic [bsr_pkg::IDX_W-1:0]     out_position,
  output logic                          last,
  output logic [bsr_pkg::HELD_W-1:0]    held_bytes,
  output logic                          nothing_held,
  output logic                          stream_ended
);
  import bsr_pkg::*;

  cmd_t front_cmd;
  cmd_t queue_cmd;
  logic front_valid;
  logic front_ready;
  logic queue_valid;
  logic queue_ready;

  // front: accept and classify
  bsr_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .has_data    (has_data),
    .byte_index  (byte_index),
    .data_byte   (data_byte),
    .ends_stream (ends_stream),
    .cmd_valid   (front_valid),
    .cmd_ready   (front_ready),
    .cmd         (front_cmd)
  );

  // command queue
  bsr_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .push_cmd   (front_cmd),
    .pop_valid  (queue_valid),
    .pop_ready  (queue_ready),
    .pop_cmd    (queue_cmd)
  );

  // back: store, drain, results
  bsr_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_data     (cfg_data),
    .cmd_valid    (queue_valid),
    .cmd_ready    (queue_ready),
    .cmd          (queue_cmd),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .has_byte     (has_byte),
    .out_byte     (out_byte),
    .out_position (out_position),
    .last         (last),
    .held_bytes   (held_bytes),
    .nothing_held (nothing_held),
    .stream_ended (stream_ended)
  );

endmodule

>>> tb/tb_byte_stream_reassembler.sv
// self-checking testbench for the byte stream reassembler
`timescale 1ns / 1ps

module tb_byte_stream_reassembler;
  import bsr_pkg::*;

  // one expected output beat
  typedef struct {
    logic              has_byte;
    logic [BYTE_W-1:0] byte_val;
    logic [IDX_W-1:0]  pos;
    logic              is_last;
    logic [HELD_W-1:0] held;
    logic              none_held;
    logic              ended;
  } beat_t;

  logic                 clk;
  logic                 rst = 1'b1;
  logic                 cfg_write = 1'b0;
  logic [WIN_CFG_W-1:0] cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic                 has_data = 1'b0;
  logic [IDX_W-1:0]     byte_index = '0;
  logic [BYTE_W-1:0]    data_byte = '0;
  logic                 ends_stream = 1'b0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic                 has_byte;
  logic [BYTE_W-1:0]    out_byte;
  logic [IDX_W-1:0]     out_position;
  logic                 last;
  logic [HELD_W-1:0]    held_bytes;
  logic                 nothing_held;
  logic                 stream_ended;

  // predicted block state
  logic [BYTE_W-1:0]    pend_byte [WIN_DEPTH];
  logic                 pend_mark [WIN_DEPTH];
  logic [IDX_W-1:0]     next_pos = '0;
  logic [IDX_W-1:0]     end_pos = '0;
  logic                 end_seen = 1'b0;
  logic [HELD_W-1:0]    pend_count = '0;
  logic                 ended_seen = 1'b0;
  logic [SLOT_W-1:0]    head = '0;
  logic [WIN_CFG_W-1:0] win_reg = WIN_RESET;

  beat_t expected_beats[$];
  int    errors = 0;
  int    items_sent = 0;
  bit    steady = 1'b0;

  byte_stream_reassembler dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .has_data     (has_data),
    .byte_index   (byte_index),
    .data_byte    (data_byte),
    .ends_stream  (ends_stream),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .has_byte     (has_byte),
    .out_byte     (out_byte),
    .out_position (out_position),
    .last         (last),
    .held_bytes   (held_bytes),
    .nothing_held (nothing_held),
    .stream_ended (stream_ended)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("byte_stream_reassembler: mismatch");
    $finish;
  end

  // receiver stalls at random except in steady stretches
  always @(posedge clk) begin
    out_ready <= steady || ($urandom_range(0, 99) >= 28);
  end

  // usable window after saturation at the store depth
  function automatic int live_window();
    return (int'(win_reg) > WIN_DEPTH) ? WIN_DEPTH : int'(win_reg);
  endfunction

  // store one item and queue the in-order run it releases, or a status beat
  task automatic reassemble(input logic hd, input logic [IDX_W-1:0] idx,
                            input logic [BYTE_W-1:0] val, input logic es);
    logic [IDX_W-1:0]  off;
    logic [SLOT_W-1:0] slot;
    beat_t             r;
    int                n;
    n = 0;
    if (es) begin
      end_pos  = idx + IDX_W'(hd);
      end_seen = 1'b1;
    end
    if (hd) begin
      off = idx - next_pos;
      if (off < IDX_W'(live_window())) begin
        slot = SLOT_W'((int'(head) + int'(off)) % WIN_DEPTH);
        pend_byte[slot] = val;
        if (!pend_mark[slot]) begin
          pend_mark[slot] = 1'b1;
          pend_count++;
        end
      end
    end
    if (end_seen && next_pos == end_pos) ended_seen = 1'b1;
    // drain the contiguous run at the head
    while (pend_mark[head]) begin
      r.has_byte = 1'b1;
      r.byte_val = pend_byte[head];
      r.pos      = next_pos;
      pend_mark[head] = 1'b0;
      pend_count--;
      next_pos++;
      head = SLOT_W'((int'(head) + 1) % WIN_DEPTH);
      if (end_seen && next_pos == end_pos) ended_seen = 1'b1;
      r.is_last   = 1'b0;
      r.held      = pend_count;
      r.none_held = (pend_count == 0);
      r.ended     = ended_seen;
      expected_beats.push_back(r);
      n++;
    end
    // status beat when nothing was delivered
    if (n == 0) begin
      r.has_byte  = 1'b0;
      r.byte_val  = '0;
      r.pos       = next_pos;
      r.is_last   = 1'b0;
      r.held      = pend_count;
      r.none_held = (pend_count == 0);
      r.ended     = ended_seen;
      expected_beats.push_back(r);
    end
    r = expected_beats.pop_back();
    r.is_last = 1'b1;
    expected_beats.push_back(r);
  endtask

  // present one input beat and wait for it to be taken
  task automatic send_item(input logic hd, input logic [IDX_W-1:0] idx,
                           input logic [BYTE_W-1:0] val, input logic es);
    while (!steady && $urandom_range(0, 99) < 28) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    has_data    <= hd;
    byte_index  <= idx;
    data_byte   <= val;
    ends_stream <= es;
    @(negedge clk);
    while (!in_ready) @(negedge clk);
    @(posedge clk);
    reassemble(hd, idx, val, es);
    items_sent++;
  endtask

  // let every queued result come out before touching the register
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_window(input logic [WIN_CFG_W-1:0] v);
    cfg_write <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    cfg_write <= 1'b0;
    win_reg = v;
  endtask

  // bytes at consecutive positions in shuffled order, head optionally last
  task automatic send_segment(input int len, input int skip, input bit head_last);
    logic [IDX_W-1:0] pos_list[$];
    logic [IDX_W-1:0] base;
    logic [IDX_W-1:0] tmp;
    int               j;
    int               k;
    base = next_pos + IDX_W'(skip);
    for (j = head_last ? 1 : 0; j < len; j++) pos_list.push_back(base + IDX_W'(j));
    for (j = pos_list.size() - 1; j > 0; j--) begin
      k = $urandom_range(0, j);
      tmp = pos_list[j];
      pos_list[j] = pos_list[k];
      pos_list[k] = tmp;
    end
    if (head_last) pos_list.push_back(base);
    for (j = 0; j < pos_list.size(); j++) begin
      send_item(1'b1, pos_list[j], BYTE_W'($urandom_range(0, 255)),
                $urandom_range(0, 49) == 0);
      // occasional resend of the same position
      if ($urandom_range(0, 9) == 0) begin
        send_item(1'b1, pos_list[j], BYTE_W'($urandom_range(0, 255)), 1'b0);
      end
    end
  endtask

  // status beats, drops on both sides of the window, reorder and overwrite
  task automatic test_reorder_and_drops();
    send_item(1'b0, '0, 8'h00, 1'b0);
    send_item(1'b1, '1, 8'hff, 1'b0);
    send_item(1'b1, IDX_W'(64), 8'h00, 1'b0);
    send_item(1'b1, IDX_W'(63), 8'ha5, 1'b0);
    send_item(1'b1, IDX_W'(63), 8'h5a, 1'b0);
    send_item(1'b1, IDX_W'(2), 8'h80, 1'b0);
    send_item(1'b1, IDX_W'(1), 8'h01, 1'b0);
    send_item(1'b1, IDX_W'(0), 8'h7f, 1'b0);
  endtask

  // end marker replaced, recorded from a dropped byte, then reached by the last byte of a run
  task automatic test_end_marker();
    send_item(1'b0, next_pos + IDX_W'(1000), 8'h00, 1'b1);
    send_item(1'b1, '1, 8'h33, 1'b1);
    send_item(1'b1, next_pos + IDX_W'(1), 8'hc3, 1'b1);
    send_item(1'b1, next_pos, 8'h3c, 1'b0);
  endtask

  // zero window, one byte window, saturated window
  task automatic test_window_register();
    wait_drained();
    write_window(WIN_CFG_W'(0));
    send_item(1'b1, next_pos, 8'h11, 1'b0);
    wait_drained();
    write_window(WIN_CFG_W'(1));
    send_item(1'b1, next_pos + IDX_W'(1), 8'h22, 1'b0);
    send_item(1'b1, next_pos, 8'h44, 1'b0);
    wait_drained();
    write_window(WIN_CFG_W'(127));
    send_item(1'b1, next_pos + IDX_W'(63), 8'h66, 1'b0);
    send_item(1'b1, next_pos + IDX_W'(64), 8'h99, 1'b0);
  endtask

  // phases of segment traffic with noise, one window setting each
  task automatic test_random_traffic();
    int p;
    int pick;
    int start;
    logic [WIN_CFG_W-1:0] win_plan [6];
    win_plan[0] = WIN_CFG_W'(64);
    win_plan[1] = WIN_CFG_W'(1);
    win_plan[2] = WIN_CFG_W'($urandom_range(2, 63));
    win_plan[3] = WIN_CFG_W'(127);
    win_plan[4] = WIN_CFG_W'($urandom_range(65, 126));
    win_plan[5] = WIN_CFG_W'(64);
    for (p = 0; p < 6; p++) begin
      wait_drained();
      steady = (p == 0);
      write_window(win_plan[p]);
      // full window released by its head byte
      if (p == 0) send_segment(WIN_DEPTH, 0, 1'b1);
      start = items_sent;
      while (items_sent - start < 20) begin
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
          send_segment(($urandom_range(0, 7) == 0) ? $urandom_range(9, live_window() + 2)
                                                   : $urandom_range(1, 8),
                       $urandom_range(0, 3), 1'b0);
        end else if (pick < 85) begin
          send_item(1'($urandom_range(0, 1)), IDX_W'($urandom()),
                    BYTE_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        end else if (pick < 93) begin
          send_item(1'b1, next_pos + IDX_W'(live_window() - 1 + $urandom_range(0, 2)),
                    BYTE_W'($urandom_range(0, 255)), 1'b0);
        end else begin
          send_item(1'b1, next_pos - IDX_W'($urandom_range(1, 3)),
                    BYTE_W'($urandom_range(0, 255)), 1'b0);
        end
      end
    end
    steady = 1'b0;
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
    end
  endtask

  // compare each output beat against the oldest prediction
  always @(negedge clk) begin : check_results
    beat_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_beats.size() == 0) begin
        errors++;
        $display("%0t: unexpected beat expected none actual pos %0h byte %0h",
                 $time, out_position, out_byte);
      end else begin
        want = expected_beats.pop_front();
        check_field("has_byte", 64'(want.has_byte), 64'(has_byte));
        check_field("out_byte", 64'(want.byte_val), 64'(out_byte));
        check_field("out_position", 64'(want.pos), 64'(out_position));
        check_field("last", 64'(want.is_last), 64'(last));
        check_field("held_bytes", 64'(want.held), 64'(held_bytes));
        check_field("nothing_held", 64'(want.none_held), 64'(nothing_held));
        check_field("stream_ended", 64'(want.ended), 64'(stream_ended));
      end
    end
  end

  initial begin
    for (int i = 0; i < WIN_DEPTH; i++) begin
      pend_byte[i] = '0;
      pend_mark[i] = 1'b0;
    end
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_reorder_and_drops();
    test_end_marker();
    test_window_register();
    test_random_traffic();
    wait_drained();
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("byte_stream_reassembler: match");
    end else begin
      $display("byte_stream_reassembler: mismatch");
    end
    $finish;
  end

endmodule
